// ===== design/mmrr_pkg.sv =====
// Shared types and codes for the memory map range reserver.
// No dependencies; imported by memory_map_range_reserver and mmrr_cell.
`timescale 1ns / 1ps
package mmrr_pkg;

	localparam logic       CMD_APPEND  = 1'b0;
	localparam logic       CMD_RESERVE = 1'b1;

	localparam logic [3:0] KIND_USABLE   = 4'd0;
	localparam logic [3:0] KIND_RESERVED = 4'd1;

	localparam logic [1:0] ST_APPLIED = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// Per-cell control: load has priority over shift.
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

// ===== design/memory_map_range_reserver.sv =====
// Top level of the memory map range reserver: FSM, cell rows, output register.
// Depends on mmrr_pkg and mmrr_cell.
//
// Usage:
//   s_* carries one request: tuser = command (0 append, 1 reserve),
//   tdata = range_start, region_length, range_end, region_kind.
//   m_* carries the table report, one entry per beat, tlast on the final one;
//   tuser = status, entry_valid; tdata = base, length, kind, total.
//   An empty table is reported as a single beat with entry_valid 0.
// Table: a row of MAX_ENTRIES cells that rotates by one cell per step, so the
//   head cell is the only read point; a second row collects the rebuilt table.
// Timing: one request at a time (s_tready high only when idle).
//   Append: an accept step, then the report steps.
//   Reserve: an accept step; for each cell slot a prep step and push steps if
//   it holds a region, else a skip step; then a commit step and the report steps.
//   The rotation of the cell row sets this order of steps.
// Stall: a report step that must emit waits while the output register is
//   full and not taken; nothing is lost or repeated.
// Reset: the table is empty, no output pending, the block is idle.
`timescale 1ns / 1ps
module memory_map_range_reserver
	import mmrr_pkg::*;
#(
	parameter int MAX_ENTRIES = 32,
	parameter int PAGE_BITS   = 12,
	parameter int ADDR_BITS   = 56
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [55:0] range_start, [111:56] region_length, [167:112] range_end,
	// [171:168] region_kind, [175:172] zero
	input  logic [175:0] s_tdata,
	// [0] command
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [55:0] entry_base, [111:56] entry_length, [115:112] entry_kind,
	// [121:116] entry_total, [127:122] zero
	output logic [127:0] m_tdata,
	// [1:0] status, [2] entry_valid
	output logic [2:0]   m_tuser,
	output logic         m_tlast
);

	localparam int AW = ADDR_BITS;
	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [AW:0] PMASK = (AW + 1)'((65'd1 << PAGE_BITS) - 65'd1);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ENTRIES);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_REPORT} state_t;

	state_t        state_q;
	logic [IW-1:0] step_q;      // rotation step
	logic [1:0]    sub_q;       // 0 prep, 1..3 push pieces
	logic [CW-1:0] count_q;
	logic [CW-1:0] rcount_q;
	logic          fail_q;
	logic [1:0]    status_q;
	logic [AW-1:0] start_q;
	logic [AW:0]   end_q;
	logic [AW:0]   re_q;
	logic [AW-1:0] lo_q;
	logic [AW:0]   hi_q;
	logic          ov_q;

	// cell rows
	logic [AW-1:0] m_base [MAX_ENTRIES];
	logic [AW-1:0] m_len  [MAX_ENTRIES];
	logic [3:0]    m_kind [MAX_ENTRIES];
	logic [AW-1:0] r_base [MAX_ENTRIES];
	logic [AW-1:0] r_len  [MAX_ENTRIES];
	logic [3:0]    r_kind [MAX_ENTRIES];
	cell_ctl_t     m_ctl  [MAX_ENTRIES];
	cell_ctl_t     r_ctl  [MAX_ENTRIES];

	// request fields
	logic          cmd;
	logic [AW-1:0] in_a, in_len, in_b;
	logic [3:0]    in_kind;
	assign cmd     = s_tuser;
	assign in_a    = AW'(s_tdata[55:0]);
	assign in_len  = AW'(s_tdata[111:56]);
	assign in_b    = AW'(s_tdata[167:112]);
	assign in_kind = s_tdata[171:168];

	logic accept, out_free, in_table, do_append, rotate, push, commit_ok;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign in_table = ({1'b0, step_q} < (IW + 1)'(count_q));
	assign do_append = accept && (cmd == CMD_APPEND) && (in_len != '0)
		&& (count_q < FULL_CNT);
	assign commit_ok = (state_q == S_COMMIT) && !fail_q;

	// head cell and its pieces
	logic [AW-1:0] hd_base, hd_len;
	logic [3:0]    hd_kind;
	assign hd_base = m_base[0];
	assign hd_len  = m_len[0];
	assign hd_kind = m_kind[0];

	logic [AW-1:0] pc_base, pc_len;
	logic [3:0]    pc_kind;
	logic          pc_ok;
	always_comb begin
		pc_base = hd_base;
		pc_len  = hd_len;
		pc_kind = hd_kind;
		pc_ok   = 1'b0;
		case (sub_q)
			2'd1: begin
				pc_ok = 1'b1;
				if (ov_q) begin
					pc_len  = lo_q - hd_base;
					pc_kind = KIND_USABLE;
				end
			end
			2'd2: begin
				pc_ok   = ov_q;
				pc_base = lo_q;
				pc_len  = AW'(hi_q - {1'b0, lo_q});
				pc_kind = KIND_RESERVED;
			end
			2'd3: begin
				pc_ok   = ov_q && !hi_q[AW];
				pc_base = hi_q[AW-1:0];
				pc_len  = AW'(re_q - hi_q);
				pc_kind = KIND_USABLE;
			end
			default: pc_ok = 1'b0;
		endcase
	end

	assign push = (state_q == S_SCAN) && (sub_q != 2'd0) && pc_ok
		&& (pc_len != '0) && !fail_q && (rcount_q < FULL_CNT);

	// rotation steps of the main row
	always_comb begin
		rotate = 1'b0;
		if (state_q == S_SCAN)
			rotate = in_table ? (sub_q == 2'd3) : 1'b1;
		else if (state_q == S_REPORT && count_q != '0)
			rotate = in_table ? out_free : 1'b1;
	end

	// a report beat is loaded into the output register this cycle
	logic emit;
	assign emit = (state_q == S_REPORT)
		&& ((count_q == '0) ? out_free : (rotate && in_table));

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cells
		localparam int NX = (i + 1) % MAX_ENTRIES;
		always_comb begin
			m_ctl[i].shift = rotate;
			m_ctl[i].load  = commit_ok || (do_append && count_q == CW'(i));
			r_ctl[i].shift = 1'b0;
			r_ctl[i].load  = push && rcount_q == CW'(i);
		end
		mmrr_cell #(.AW(AW)) u_main (
			.clk        (clk),
			.ctl        (m_ctl[i]),
			.shift_base (m_base[NX]),
			.shift_len  (m_len[NX]),
			.shift_kind (m_kind[NX]),
			.load_base  (commit_ok ? r_base[i] : in_a),
			.load_len   (commit_ok ? r_len[i] : in_len),
			.load_kind  (commit_ok ? r_kind[i] : in_kind),
			.base_q     (m_base[i]),
			.len_q      (m_len[i]),
			.kind_q     (m_kind[i])
		);
		mmrr_cell #(.AW(AW)) u_rebuild (
			.clk        (clk),
			.ctl        (r_ctl[i]),
			.shift_base (r_base[i]),
			.shift_len  (r_len[i]),
			.shift_kind (r_kind[i]),
			.load_base  (pc_base),
			.load_len   (pc_len),
			.load_kind  (pc_kind),
			.base_q     (r_base[i]),
			.len_q      (r_len[i]),
			.kind_q     (r_kind[i])
		);
	end

	// overlap prep from the head cell
	logic [AW:0] hd_end;
	assign hd_end = {1'b0, hd_base} + {1'b0, hd_len};

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && sub_q == 2'd0) begin
			re_q <= hd_end;
			ov_q <= (hd_kind == KIND_USABLE) && (end_q > {1'b0, hd_base})
				&& ({1'b0, start_q} < hd_end);
			lo_q <= (start_q > hd_base) ? start_q : hd_base;
			hi_q <= (end_q < hd_end) ? end_q : hd_end;
		end
		if (accept) begin
			start_q <= in_a & ~PMASK[AW-1:0];
			end_q   <= ({1'b0, in_b} + PMASK) & ~PMASK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			sub_q    <= '0;
			count_q  <= '0;
			rcount_q <= '0;
			fail_q   <= 1'b0;
			status_q <= ST_APPLIED;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= '0;
			m_tlast  <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && !emit)
				m_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					step_q   <= '0;
					sub_q    <= '0;
					rcount_q <= '0;
					fail_q   <= 1'b0;
					if (accept) begin
						if (cmd == CMD_APPEND) begin
							state_q <= S_REPORT;
							if (in_len == '0)
								status_q <= ST_EMPTY;
							else if (count_q >= FULL_CNT)
								status_q <= ST_FULL;
							else begin
								status_q <= ST_APPLIED;
								count_q  <= count_q + 1'b1;
							end
						end else if (in_a >= in_b) begin
							status_q <= ST_EMPTY;
							state_q  <= S_REPORT;
						end else
							state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (push)
						rcount_q <= rcount_q + 1'b1;
					else if ((state_q == S_SCAN) && (sub_q != 2'd0) && pc_ok
						&& (pc_len != '0) && (rcount_q >= FULL_CNT))
						fail_q <= 1'b1;
					if (in_table)
						sub_q <= sub_q + 1'b1;
					if (rotate) begin
						step_q <= step_q + 1'b1;
						if (step_q == LAST_IDX)
							state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					step_q <= '0;
					if (fail_q)
						status_q <= ST_FULL;
					else begin
						status_q <= ST_APPLIED;
						count_q  <= rcount_q;
					end
					state_q <= S_REPORT;
				end
				S_REPORT: begin
					if (count_q == '0) begin
						if (out_free) begin
							m_tvalid <= 1'b1;
							m_tuser  <= {1'b0, status_q};
							m_tdata  <= '0;
							m_tlast  <= 1'b1;
							state_q  <= S_IDLE;
						end
					end else if (rotate) begin
						if (in_table) begin
							m_tvalid <= 1'b1;
							m_tuser  <= {1'b1, status_q};
							m_tdata  <= {6'd0, 6'(count_q), hd_kind,
								56'(hd_len), 56'(hd_base)};
							m_tlast  <= ((IW + 1)'(step_q) + 1'b1)
								== (IW + 1)'(count_q);
						end
						step_q <= step_q + 1'b1;
						if (step_q == LAST_IDX)
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== design/mmrr_cell.sv =====
// One table cell: holds a region (base, length, kind).
// Depends on mmrr_pkg (cell_ctl_t).
`timescale 1ns / 1ps
module mmrr_cell
	import mmrr_pkg::*;
#(
	parameter int AW = 56
) (
	input  logic          clk,
	input  cell_ctl_t     ctl,
	input  logic [AW-1:0] shift_base,
	input  logic [AW-1:0] shift_len,
	input  logic [3:0]    shift_kind,
	input  logic [AW-1:0] load_base,
	input  logic [AW-1:0] load_len,
	input  logic [3:0]    load_kind,
	output logic [AW-1:0] base_q,
	output logic [AW-1:0] len_q,
	output logic [3:0]    kind_q
);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			base_q <= load_base;
			len_q  <= load_len;
			kind_q <= load_kind;
		end else if (ctl.shift) begin
			base_q <= shift_base;
			len_q  <= shift_len;
			kind_q <= shift_kind;
		end
	end

endmodule

// ===== design/mmrr_checker.sv =====
// Port-level checks for memory_map_range_reserver, bound to the top level.
// Depends on the top level's port list only.
`timescale 1ns / 1ps
module mmrr_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic [2:0]   m_tuser,
	input logic         m_tlast
);

	// one request at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while previous one in progress");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[2] |-> m_tlast && m_tdata[121:116] == 6'd0)
		else $error("empty-table report malformed");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tdata[121:116] != 6'd0 && m_tuser[1:0] != 2'd3)
		else $error("entry report with bad total or status");

endmodule

bind memory_map_range_reserver mmrr_checker u_mmrr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== tb/tb_memory_map_range_reserver.sv =====
// Testbench for memory_map_range_reserver: append and reserve requests are
// checked against an in-bench table model, beat by beat. Depends on mmrr_pkg.
`timescale 1ns / 1ps
module tb_memory_map_range_reserver;
	import mmrr_pkg::*;

	localparam int MAX_ENTRIES = 32;
	localparam int PAGE_BITS   = 12;
	localparam int ADDR_BITS   = 56;
	localparam int N_RANDOM    = 400;
	localparam int STALL_LIMIT = 4000;  // cycles with no handshake at all
	localparam int NO_STATUS   = -1;    // directed row without a typed status

	typedef logic [ADDR_BITS-1:0] addr_t;

	typedef struct {
		logic       cmd;
		addr_t      start;
		addr_t      len;
		addr_t      stop;
		logic [3:0] kind;
		int         status;
	} request_t;

	typedef struct {
		logic [1:0] status;
		logic       valid;
		addr_t      base;
		addr_t      len;
		logic [3:0] kind;
		logic [5:0] total;
		logic       last;
	} entry_beat_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [175:0] s_tdata;   // start, length, end, kind, zero pad (low bits first)
	logic         s_tuser;   // command
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;   // base, length, kind, total, zero pad
	logic [2:0]   m_tuser;   // status, entry_valid
	logic         m_tlast;

	memory_map_range_reserver uut (.*);

	// model of the region table
	addr_t      map_base [MAX_ENTRIES];
	addr_t      map_len  [MAX_ENTRIES];
	logic [3:0] map_kind [MAX_ENTRIES];
	int         map_count;
	addr_t      new_base [MAX_ENTRIES];
	addr_t      new_len  [MAX_ENTRIES];
	logic [3:0] new_kind [MAX_ENTRIES];
	int         new_count;

	entry_beat_t report_q[$];
	request_t    dir_rows[$];
	int          errors;
	int          n_append, n_reserve, n_full, n_empty, n_beats;
	int          send_idle_pct, recv_idle_pct;
	int          quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic request_t mk(logic cmd, addr_t start, addr_t len, addr_t stop,
			logic [3:0] kind, int status);
		request_t r;
		r.cmd = cmd; r.start = start; r.len = len; r.stop = stop;
		r.kind = kind; r.status = status;
		return r;
	endfunction

	// zero pieces are skipped; returns 0 when the rebuilt table is full
	function automatic bit stage_piece(logic [56:0] base, logic [56:0] len, logic [3:0] kind);
		if (len == 0)
			return 1'b1;
		if (new_count >= MAX_ENTRIES)
			return 1'b0;
		new_base[new_count] = base[ADDR_BITS-1:0];
		new_len[new_count]  = len[ADDR_BITS-1:0];
		new_kind[new_count] = kind;
		new_count++;
		return 1'b1;
	endfunction

	function automatic logic [1:0] reserve_range(addr_t start, addr_t stop);
		logic [56:0] pmask, top, lo, hi, rs, re, cut_lo, cut_hi;
		pmask = (57'd1 << PAGE_BITS) - 57'd1;
		top   = 57'd1 << ADDR_BITS;
		if (start >= stop)
			return ST_EMPTY;
		lo = {1'b0, start} & ~pmask;
		hi = ({1'b0, stop} + pmask) & ~pmask;
		if (hi > top)
			hi = top;
		new_count = 0;
		for (int i = 0; i < map_count; i++) begin
			rs = {1'b0, map_base[i]};
			re = rs + {1'b0, map_len[i]};
			if (map_kind[i] != KIND_USABLE || hi <= rs || lo >= re) begin
				if (!stage_piece(rs, {1'b0, map_len[i]}, map_kind[i]))
					return ST_FULL;
				continue;
			end
			cut_lo = (lo > rs) ? lo : rs;
			cut_hi = (hi < re) ? hi : re;
			if (!stage_piece(rs, cut_lo - rs, KIND_USABLE))
				return ST_FULL;
			if (!stage_piece(cut_lo, cut_hi - cut_lo, KIND_RESERVED))
				return ST_FULL;
			// a tail starting at the end of the address space is dropped
			if (cut_hi < top && !stage_piece(cut_hi, re - cut_hi, KIND_USABLE))
				return ST_FULL;
		end
		map_count = new_count;
		for (int i = 0; i < new_count; i++) begin
			map_base[i] = new_base[i];
			map_len[i]  = new_len[i];
			map_kind[i] = new_kind[i];
		end
		return ST_APPLIED;
	endfunction

	// applies one request to the model and queues the table report it causes
	function automatic logic [1:0] apply_request(request_t r);
		logic [1:0]  st;
		entry_beat_t b;
		if (r.cmd == CMD_APPEND) begin
			n_append++;
			if (r.len == 0)
				st = ST_EMPTY;
			else if (map_count >= MAX_ENTRIES)
				st = ST_FULL;
			else begin
				map_base[map_count] = r.start;
				map_len[map_count]  = r.len;
				map_kind[map_count] = r.kind;
				map_count++;
				st = ST_APPLIED;
			end
		end else begin
			n_reserve++;
			st = reserve_range(r.start, r.stop);
		end
		if (st == ST_FULL)
			n_full++;
		if (st == ST_EMPTY)
			n_empty++;
		if (map_count == 0) begin
			b = '{st, 1'b0, '0, '0, 4'd0, 6'd0, 1'b1};
			report_q.push_back(b);
		end
		for (int k = 0; k < map_count; k++) begin
			b = '{st, 1'b1, map_base[k], map_len[k], map_kind[k], 6'(map_count),
				k == map_count - 1};
			report_q.push_back(b);
		end
		return st;
	endfunction

	function automatic addr_t rand_addr();
		return ($urandom_range(0, 9) == 0) ? addr_t'({$urandom, $urandom})
			: addr_t'($urandom_range(0, 32'h3F_FFFF));
	endfunction

	// mostly overlapping regions in a low window, some full-width noise
	function automatic request_t rand_request();
		request_t r;
		int       pick;
		r.cmd   = ($urandom_range(0, 99) < 45) ? CMD_APPEND : CMD_RESERVE;
		r.start = rand_addr();
		r.kind  = ($urandom_range(0, 2) == 0) ? 4'($urandom) : KIND_USABLE;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			r.len = '0;
		else if (pick < 20)
			r.len = addr_t'({$urandom, $urandom});
		else
			r.len = addr_t'($urandom_range(1, 32'h4_0000));
		pick = $urandom_range(0, 99);
		if (pick < 10)
			r.stop = addr_t'($urandom) % (r.start + 1);
		else if (pick < 20)
			r.stop = addr_t'({$urandom, $urandom});
		else
			r.stop = r.start + addr_t'($urandom_range(1, 32'h4_0000));
		r.status = NO_STATUS;
		return r;
	endfunction

	task automatic send(request_t r);
		logic [1:0] st;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = r.cmd;
		s_tdata  = {4'd0, r.kind, r.stop, r.len, r.start};
		do @(posedge clk); while (!s_tready);
		st = apply_request(r);
		if (r.status != NO_STATUS && st != 2'(r.status)) begin
			$error("status: expected %0d actual model %0d", r.status, st);
			errors++;
		end
		if ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	endtask

	// receiver backpressure
	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// report checker and no-progress watchdog
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			entry_beat_t e;
			n_beats++;
			if (report_q.size() == 0) begin
				$error("unexpected report beat base %h", m_tdata[55:0]);
				errors++;
			end else begin
				e = report_q.pop_front();
				if (m_tuser[1:0] != e.status) begin
					$error("status: expected %0d actual %0d", e.status, m_tuser[1:0]);
					errors++;
				end
				if (m_tuser[2] != e.valid) begin
					$error("entry_valid: expected %0d actual %0d", e.valid, m_tuser[2]);
					errors++;
				end
				if (m_tdata[55:0] != e.base) begin
					$error("entry_base: expected %h actual %h", e.base, m_tdata[55:0]);
					errors++;
				end
				if (m_tdata[111:56] != e.len) begin
					$error("entry_length: expected %h actual %h", e.len, m_tdata[111:56]);
					errors++;
				end
				if (m_tdata[115:112] != e.kind) begin
					$error("entry_kind: expected %0d actual %0d", e.kind, m_tdata[115:112]);
					errors++;
				end
				if (m_tdata[121:116] != e.total) begin
					$error("entry_total: expected %0d actual %0d", e.total,
						m_tdata[121:116]);
					errors++;
				end
				if (m_tlast != e.last) begin
					$error("last: expected %0d actual %0d", e.last, m_tlast);
					errors++;
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		addr_t top_addr;
		top_addr = '1;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		errors = 0; n_append = 0; n_reserve = 0; n_full = 0; n_empty = 0; n_beats = 0;
		quiet_cycles = 0;
		map_count = 0;
		send_idle_pct = 19;
		recv_idle_pct = 55;

		// empty-table cases, extremes, splits and the top of the address space
		dir_rows.push_back(mk(CMD_APPEND, 56'h1000, 56'h0, 56'h0, 4'd0, ST_EMPTY));
		dir_rows.push_back(mk(CMD_RESERVE, 56'h5000, 56'h0, 56'h4000, 4'd0, ST_EMPTY));
		dir_rows.push_back(mk(CMD_RESERVE, 56'h0, 56'h0, top_addr, 4'hF, ST_APPLIED));
		dir_rows.push_back(mk(CMD_APPEND, 56'h0, 56'h1_0000, 56'h0, KIND_USABLE, ST_APPLIED));
		dir_rows.push_back(mk(CMD_APPEND, top_addr, top_addr, top_addr, 4'hF, ST_APPLIED));
		dir_rows.push_back(mk(CMD_APPEND, 56'hFF_FFFF_FFFF_0000, 56'h2_0000, 56'h0,
			KIND_USABLE, ST_APPLIED));
		dir_rows.push_back(mk(CMD_APPEND, 56'h10_0000, 56'h8000, 56'h0, KIND_RESERVED,
			ST_APPLIED));
		dir_rows.push_back(mk(CMD_APPEND, 56'h20_0000, 56'h8000, 56'h0, 4'd7, ST_APPLIED));
		dir_rows.push_back(mk(CMD_RESERVE, 56'h1234, 56'h0, 56'h5678, 4'd0, NO_STATUS));
		dir_rows.push_back(mk(CMD_RESERVE, 56'h9000, 56'h0, 56'h9000, 4'd0, ST_EMPTY));
		dir_rows.push_back(mk(CMD_RESERVE, 56'hFF_FFFF_FFFF_F800, 56'h0, top_addr, 4'd0,
			NO_STATUS));
		dir_rows.push_back(mk(CMD_RESERVE, 56'h0, 56'h0, 56'h1000, 4'd0, NO_STATUS));
		dir_rows.push_back(mk(CMD_RESERVE, 56'h10_0000, 56'h0, 56'h20_8000, 4'd0, NO_STATUS));
		dir_rows.push_back(mk(CMD_APPEND, 56'h40_0000, 56'h40_0000, 56'h0, KIND_USABLE,
			ST_APPLIED));
		dir_rows.push_back(mk(CMD_RESERVE, 56'h0, 56'h0, top_addr, 4'd0, NO_STATUS));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send(dir_rows[i]);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				send_idle_pct = 55;
				recv_idle_pct = 19;
			end else if (i == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			send(rand_request());
		end
		@(negedge clk);
		s_tvalid = 1'b0;

		// drain, then give the block time to show any stray beat
		while (report_q.size() != 0)
			@(posedge clk);
		repeat (5 * MAX_ENTRIES + 50) @(posedge clk);
		if (report_q.size() != 0)
			errors++;

		$display("Ran %0d appends and %0d reserves, %0d report beats checked.",
			n_append, n_reserve, n_beats);
		$display("Table-full drops: %0d, empty requests: %0d, final table size: %0d.",
			n_full, n_empty, map_count);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
